FILE: rtl/core/ole_pkg.sv
// Shared types and constants for the ordered list engine.
// Holds operation codes, status codes, controller states and the cell command word.
// No dependencies.
`default_nettype none

package ole_pkg;

    // Widest position/count and entry the cell command word has to carry.
    localparam int POS_W  = 11;
    localparam int DATA_W = 64;

    typedef enum logic [3:0] {
        ACT_APPEND     = 4'd0,
        ACT_OVERWRITE  = 4'd1,
        ACT_INSERT     = 4'd2,
        ACT_REMOVE     = 4'd3,
        ACT_DROP_FIRST = 4'd4,
        ACT_DROP_LAST  = 4'd5,
        ACT_CLEAR      = 4'd6,
        ACT_FIND       = 4'd7,
        ACT_READ       = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT
    } t_state;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_WRITE,
        CM_INSERT,
        CM_SHIFT_DOWN
    } t_cell_mode;

    // Broadcast to every cell of the chain in each cycle.
    typedef struct packed {
        t_cell_mode        mode;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  count;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

    localparam logic [4:0] FOUND_NONE = 5'h1F;

endpackage

`default_nettype wire

FILE: rtl/core/ole_req_if.sv
// Request channel of the ordered list engine: valid/ready plus one operation word.
// Depends on nothing.
`default_nettype none

interface ole_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] action;
    logic [31:0] value;
    logic [4:0] position;
    logic [4:0] amount;

    modport source (output valid, output action, output value, output position,
                    output amount, input ready);
    modport sink   (input valid, input action, input value, input position,
                    input amount, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ole_rsp_if.sv
// Response channel of the ordered list engine: valid/ready plus one result word.
// Depends on nothing.
`default_nettype none

interface ole_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [4:0] found_position;
    logic [31:0]       read_value;
    logic [4:0]        entry_count;
    logic [1:0]        status;

    modport source (output valid, output found_position, output read_value,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input found_position, input read_value,
                    input entry_count, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ole_cell.sv
// One storage cell of the list chain: holds one entry, trades data with its neighbors.
// Depends on ole_pkg.
`default_nettype none

module ole_cell #(
    parameter int IDX         = 0,
    parameter int ENTRY_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire ole_pkg::t_cell_cmd     i_cmd,
    input  wire logic [ENTRY_WIDTH-1:0] i_left,
    input  wire logic [ENTRY_WIDTH-1:0] i_right,
    output logic      [ENTRY_WIDTH-1:0] o_data,
    output logic                        o_match,
    output logic      [ENTRY_WIDTH-1:0] o_rd
);

    localparam logic [ole_pkg::POS_W-1:0] MY_IDX = ole_pkg::POS_W'(IDX);

    logic [ENTRY_WIDTH-1:0] r_data;
    logic [ENTRY_WIDTH-1:0] n_data;
    logic [ENTRY_WIDTH-1:0] w_value;

    assign w_value = i_cmd.value[ENTRY_WIDTH-1:0];

    always_comb begin
        n_data = r_data;
        case (i_cmd.mode)
            ole_pkg::CM_WRITE: begin
                if (MY_IDX == i_cmd.pos) n_data = w_value;
            end
            ole_pkg::CM_INSERT: begin
                if (MY_IDX == i_cmd.pos)     n_data = w_value;
                else if (MY_IDX > i_cmd.pos) n_data = i_left;
            end
            ole_pkg::CM_SHIFT_DOWN: begin
                if (MY_IDX >= i_cmd.pos) n_data = i_right;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    // Only live entries may report a hit.
    assign o_match = (MY_IDX < i_cmd.count) && (r_data == w_value);
    assign o_rd    = (MY_IDX == i_cmd.pos) ? r_data : '0;

endmodule

`default_nettype wire

FILE: rtl/core/ole_ctrl.sv
// Controller of the ordered list engine: decodes operations, keeps the count,
// drives the cell chain and holds the response register. Depends on ole_pkg.
`default_nettype none

module ole_ctrl #(
    parameter int CAPACITY    = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    ole_req_if.sink                     i_req,
    ole_rsp_if.source                   o_rsp,
    input  wire logic [CAPACITY-1:0]    i_match,
    input  wire logic [ENTRY_WIDTH-1:0] i_rd,
    output ole_pkg::t_cell_cmd          o_cmd
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    ole_pkg::t_state  r_state, n_state;
    ole_pkg::t_action r_action;
    logic [31:0]      r_value;
    logic [4:0]       r_pos;
    logic [4:0]       r_amt;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_steps, n_steps;

    logic              r_out_valid;
    logic [4:0]        r_found;
    logic [31:0]       r_rd;
    logic [4:0]        r_count_out;
    ole_pkg::t_status  r_status;

    logic              w_slot_free;
    logic              w_accept;
    logic [CMPW-1:0]   w_pos_c, w_amt_c, w_cnt_c;
    logic [CW-1:0]     w_drop;
    logic [CAPACITY-1:0] w_first;
    logic [IW-1:0]     w_idx;
    logic [4:0]        w_found;
    logic [31:0]       w_rd;
    ole_pkg::t_status  w_status;
    logic              w_multi;

    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ole_pkg::S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_pos_c = CMPW'(r_pos);
    assign w_amt_c = CMPW'(r_amt);
    assign w_cnt_c = CMPW'(r_count);
    assign w_drop  = (w_amt_c > w_cnt_c) ? r_count : CW'(r_amt);
    assign w_multi = (r_action == ole_pkg::ACT_DROP_FIRST) && (r_count != '0)
                     && (w_drop > CW'(1));

    // Lowest live hit: isolate the first set bit, then encode it.
    assign w_first = i_match & (~i_match + CAPACITY'(1));

    always_comb begin
        logic [CAPACITY-1:0] v_mask;
        w_idx = '0;
        for (int k = 0; k < IW; k++) begin
            for (int i = 0; i < CAPACITY; i++) begin
                v_mask[i] = i[k];
            end
            w_idx[k] = |(w_first & v_mask);
        end
    end

    assign w_found = (|i_match) ? 5'(w_idx) : ole_pkg::FOUND_NONE;
    assign w_rd    = 32'(ole_pkg::DATA_W'(i_rd));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ole_pkg::S_IDLE: begin
                if (w_accept) n_state = ole_pkg::S_EXEC;
            end
            ole_pkg::S_EXEC: begin
                if (w_slot_free) n_state = w_multi ? ole_pkg::S_SHIFT : ole_pkg::S_IDLE;
            end
            ole_pkg::S_SHIFT: begin
                if (r_steps == CW'(1)) n_state = ole_pkg::S_IDLE;
            end
            default: n_state = ole_pkg::S_IDLE;
        endcase
    end

    // Outputs: cell command, new count, status.
    always_comb begin
        o_cmd.mode  = ole_pkg::CM_HOLD;
        o_cmd.pos   = ole_pkg::POS_W'(r_pos);
        o_cmd.count = ole_pkg::POS_W'(r_count);
        o_cmd.value = ole_pkg::DATA_W'(r_value);
        n_count     = r_count;
        n_steps     = r_steps;
        w_status    = ole_pkg::ST_DONE;
        unique case (r_state)
            ole_pkg::S_IDLE: begin
            end
            ole_pkg::S_EXEC: begin
                case (r_action)
                    ole_pkg::ACT_APPEND: begin
                        o_cmd.pos = ole_pkg::POS_W'(r_count);
                        if (r_count >= CAP_C) begin
                            w_status = ole_pkg::ST_FULL;
                        end else begin
                            o_cmd.mode = ole_pkg::CM_WRITE;
                            n_count    = r_count + CW'(1);
                        end
                    end
                    ole_pkg::ACT_OVERWRITE: begin
                        if (w_pos_c >= w_cnt_c) w_status = ole_pkg::ST_RANGE;
                        else                    o_cmd.mode = ole_pkg::CM_WRITE;
                    end
                    ole_pkg::ACT_INSERT: begin
                        if (w_pos_c > w_cnt_c) begin
                            w_status = ole_pkg::ST_RANGE;
                        end else if (r_count >= CAP_C) begin
                            w_status = ole_pkg::ST_FULL;
                        end else begin
                            o_cmd.mode = ole_pkg::CM_INSERT;
                            n_count    = r_count + CW'(1);
                        end
                    end
                    ole_pkg::ACT_REMOVE: begin
                        if (w_pos_c >= w_cnt_c) begin
                            w_status = ole_pkg::ST_RANGE;
                        end else begin
                            o_cmd.mode = ole_pkg::CM_SHIFT_DOWN;
                            n_count    = r_count - CW'(1);
                        end
                    end
                    ole_pkg::ACT_DROP_FIRST: begin
                        o_cmd.pos = '0;
                        if (r_count == '0) begin
                            w_status = ole_pkg::ST_RANGE;
                        end else if (w_drop != '0) begin
                            // First step here, the rest one per cycle in S_SHIFT.
                            o_cmd.mode = ole_pkg::CM_SHIFT_DOWN;
                            n_count    = r_count - w_drop;
                            n_steps    = w_drop - CW'(1);
                        end
                    end
                    ole_pkg::ACT_DROP_LAST: begin
                        if (r_count == '0) w_status = ole_pkg::ST_RANGE;
                        else               n_count = r_count - CW'(1);
                    end
                    ole_pkg::ACT_CLEAR: begin
                        n_count = '0;
                    end
                    ole_pkg::ACT_READ: begin
                        if (w_pos_c >= w_cnt_c) w_status = ole_pkg::ST_RANGE;
                    end
                    default: begin
                    end
                endcase
                if (!w_slot_free) begin
                    o_cmd.mode = ole_pkg::CM_HOLD;
                    n_count    = r_count;
                    n_steps    = r_steps;
                end
            end
            ole_pkg::S_SHIFT: begin
                o_cmd.mode = ole_pkg::CM_SHIFT_DOWN;
                o_cmd.pos  = '0;
                n_steps    = r_steps - CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ole_pkg::S_IDLE;
            r_count     <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_steps <= n_steps;
            if (r_state == ole_pkg::S_EXEC && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= ole_pkg::t_action'(i_req.action);
            r_value  <= i_req.value;
            r_pos    <= i_req.position;
            r_amt    <= i_req.amount;
        end
        if (r_state == ole_pkg::S_EXEC && w_slot_free) begin
            r_found     <= (r_action == ole_pkg::ACT_FIND) ? w_found : ole_pkg::FOUND_NONE;
            r_rd        <= (r_action == ole_pkg::ACT_READ && w_status == ole_pkg::ST_DONE)
                           ? w_rd : '0;
            r_count_out <= 5'(n_count);
            r_status    <= w_status;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.found_position = $signed(r_found);
    assign o_rsp.read_value     = r_rd;
    assign o_rsp.entry_count    = r_count_out;
    assign o_rsp.status         = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ole_pkg::ST_FULL) |-> (r_count_out == 5'(CAPACITY)))
        else $error("full status reported with a list that is not full");

    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ole_pkg::S_SHIFT) |=> (r_count == $past(r_count)))
        else $error("count moved during a multi-step drop");

    a_shift_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ole_pkg::S_SHIFT) |-> (r_steps != '0))
        else $error("drop sequencer running with no steps left");

endmodule

`default_nettype wire

FILE: rtl/core/ordered_list_engine_unit.sv
// Ordered list engine top level: a controller and a chain of entry cells.
// Depends on ole_pkg, ole_req_if, ole_rsp_if, ole_cell and ole_ctrl.
//
//   Channel  Dir  Payload                                          Handshake
//   i_req    in   action, value, position, amount                  valid/ready
//   o_rsp    out  found_position, read_value, entry_count, status  valid/ready
//
// One operation is in flight at a time: a word is taken in S_IDLE and
// executed across all cells in S_EXEC, once the response register is free.
// Dropping the first n entries (at most the entry count) moves the chain
// one cell per cycle from then on. A new word is taken while the previous
// result still waits in the response register; a stalled response holds
// execution. Reset empties the list; the entry cells are not cleared.
`default_nettype none

module ordered_list_engine_unit #(
    parameter int CAPACITY    = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ole_req_if.sink   i_req,
    ole_rsp_if.source o_rsp
);

    ole_pkg::t_cell_cmd     w_cmd;
    logic [ENTRY_WIDTH-1:0] w_data [CAPACITY];
    logic [ENTRY_WIDTH-1:0] w_rd   [CAPACITY];
    logic [CAPACITY-1:0]    w_match;
    logic [CAPACITY-1:0]    w_rd_t [ENTRY_WIDTH];
    logic [ENTRY_WIDTH-1:0] w_rd_or;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] w_left;
        logic [ENTRY_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner_r
            assign w_right = w_data[g+1];
        end
        ole_cell #(
            .IDX         (g),
            .ENTRY_WIDTH (ENTRY_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_match (w_match[g]),
            .o_rd    (w_rd[g])
        );
    end

    // Only the addressed cell drives non-zero read data, so an OR collects it.
    always_comb begin
        for (int b = 0; b < ENTRY_WIDTH; b++) begin
            for (int i = 0; i < CAPACITY; i++) begin
                w_rd_t[b][i] = w_rd[i][b];
            end
            w_rd_or[b] = |w_rd_t[b];
        end
    end

    ole_ctrl #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_match (w_match),
        .i_rd    (w_rd_or),
        .o_cmd   (w_cmd)
    );

endmodule

`default_nettype wire
